// ===== sv/adpcm_enc_pkg.sv =====
`timescale 1ns / 1ps

package adpcm_enc_pkg;

  localparam int SAMPLE_W = 16;
  localparam int STEP_W   = 15;
  localparam int CODE_W   = 3;
  localparam int NIB_W    = 4;
  localparam int BYTE_W   = 8;
  localparam int CFG_W    = 2;
  localparam int SCALE_W  = 16;
  localparam int PROD_W   = SCALE_W + STEP_W;
  localparam int MAG_W    = SAMPLE_W + 1;
  localparam int DELTA_W  = SAMPLE_W + 1;
  localparam int WIDE_W   = SAMPLE_W + 2;
  localparam int PC_W     = 2;

  localparam int SCALE_SHIFT = 14;

  localparam logic [STEP_W-1:0] STEP_MIN = 15'h007F;
  localparam logic [STEP_W-1:0] STEP_MAX = 15'h6000;
  localparam logic signed [SAMPLE_W-1:0] PRED_MAX = 16'sh7FFF;
  localparam logic signed [SAMPLE_W-1:0] PRED_MIN = -16'sh8000;
  localparam logic [CODE_W-1:0] CODE_MAX = 3'd7;

  // micro-op of one step
  typedef enum logic [1:0] {
    OP_WAIT,
    OP_QUANT,
    OP_MUL,
    OP_COMMIT
  } uop_t;

  // when true, the sequencer jumps to the target, else falls through to the next step
  typedef enum logic [1:0] {
    JC_NEVER,
    JC_NO_ACCEPT,
    JC_MORE,
    JC_OUT_BUSY
  } jcond_t;

  typedef struct packed {
    uop_t              op;
    jcond_t            cond;
    logic [PC_W-1:0]   target;
  } uword_t;

  localparam logic [PC_W-1:0] PC_WAIT   = 2'd0;
  localparam logic [PC_W-1:0] PC_QUANT  = 2'd1;
  localparam logic [PC_W-1:0] PC_MUL    = 2'd2;
  localparam logic [PC_W-1:0] PC_COMMIT = 2'd3;

  function automatic uword_t ucode_rom(input logic [PC_W-1:0] pc);
    uword_t w;
    unique case (pc)
      PC_WAIT:   w = '{op: OP_WAIT,   cond: JC_NO_ACCEPT, target: PC_WAIT};
      PC_QUANT:  w = '{op: OP_QUANT,  cond: JC_MORE,      target: PC_QUANT};
      PC_MUL:    w = '{op: OP_MUL,    cond: JC_NEVER,     target: PC_MUL};
      PC_COMMIT: w = '{op: OP_COMMIT, cond: JC_OUT_BUSY,  target: PC_COMMIT};
      default:   w = '{op: OP_WAIT,   cond: JC_NO_ACCEPT, target: PC_WAIT};
    endcase
    return w;
  endfunction

  function automatic logic [SCALE_W-1:0] step_scale(input logic [CODE_W-1:0] code);
    logic [SCALE_W-1:0] s;
    unique case (code) inside
      3'd0, 3'd1, 3'd2, 3'd3: s = 16'h3980;
      3'd4:                   s = 16'h4CC0;
      3'd5:                   s = 16'h6640;
      3'd6:                   s = 16'h8000;
      3'd7:                   s = 16'h9980;
      default:                s = 16'h3980;
    endcase
    return s;
  endfunction

endpackage

// ===== sv/adpcm_nibble_encoder.sv =====
`timescale 1ns / 1ps

// 4-bit ADPCM-B style encoder for one or two interleaved channels. Each accepted
// 16-bit sample is quantized against its channel's prediction and step size; two
// nibbles go out per byte, earlier sample in bits 3:0, and a sample flagged
// end_of_stream flushes its nibble (alone if none waits), resetting all channel state.
// A small microcode sequencer runs each sample: accept, a quantizer loop of one
// compare-subtract per cycle (the magnitude code sets the loop count), a step
// multiply, and a commit step, which holds while it has a byte for a full output
// register. The output register lets the next sample be taken while a byte waits.
// The user must write num_channels through cfg_wr_en / cfg_wr_data only while
// the block is idle; the block itself does not enforce it.
module adpcm_nibble_encoder
  import adpcm_enc_pkg::*;
#(
  parameter int MAX_CHANNELS = 2
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_wr_en,
  input  logic [CFG_W-1:0]           cfg_wr_data,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [SAMPLE_W-1:0] in_sample,
  input  logic                       in_end_of_stream,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [BYTE_W-1:0]          out_packed_byte,
  output logic                       out_final_byte
);

  localparam int CH_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

  // sequencer
  logic [PC_W-1:0] pc_r, pc_nxt;
  uword_t          uw;
  logic            jump;

  // architectural state
  logic signed [SAMPLE_W-1:0] pred_r [MAX_CHANNELS];
  logic [STEP_W-1:0]          step_r [MAX_CHANNELS];
  logic [CH_W-1:0]            ch_idx_r;
  logic                       pending_r;
  logic [NIB_W-1:0]           held_r;
  logic [CFG_W-1:0]           num_ch_r;

  // per-sample datapath
  logic [CH_W-1:0]          ch_r;
  logic                     eos_r;
  logic                     neg_r;
  logic [MAG_W-1:0]         rem_r;
  logic [CODE_W-1:0]        code_r;
  logic [PROD_W-1:0]        prod_r;
  logic signed [SAMPLE_W-1:0] pred_upd_r;

  logic                     out_valid_r;
  logic [BYTE_W-1:0]        out_byte_r;
  logic                     out_final_r;

  logic [CFG_W-1:0]           n_act;
  logic [CH_W-1:0]            ch_sel, ch_next;
  logic signed [SAMPLE_W-1:0] pred_sel, pred_cur;
  logic [STEP_W-1:0]          step_cur;
  logic [STEP_W-1:0]          quarter;
  logic signed [MAG_W-1:0]    diff;
  logic [MAG_W-1:0]           mag;
  logic                       more;
  logic [DELTA_W-1:0]         delta;
  logic signed [WIDE_W-1:0]   pred_wide;
  logic signed [SAMPLE_W-1:0] pred_clamp;
  logic [PROD_W-SCALE_SHIFT-1:0] ns_raw;
  logic [STEP_W-1:0]          ns_clamp;
  logic [NIB_W-1:0]           nib;
  logic                       emit;
  logic                       accept;
  logic                       commit;

  assign uw = ucode_rom(pc_r);

  // 0 acts as mono, 3 as stereo, capped by the build
  always_comb begin
    case (num_ch_r)
      2'd0:    n_act = 2'd1;
      2'd3:    n_act = 2'd2;
      default: n_act = num_ch_r;
    endcase
    if (int'(n_act) > MAX_CHANNELS) n_act = CFG_W'(MAX_CHANNELS);
  end

  assign ch_sel  = (int'(ch_idx_r) < int'(n_act)) ? ch_idx_r : '0;
  assign ch_next = ((int'(ch_r) + 1) >= int'(n_act)) ? '0 : CH_W'(int'(ch_r) + 1);

  always_comb begin
    pred_sel = '0;
    pred_cur = '0;
    step_cur = STEP_MIN;
    for (int c = 0; c < MAX_CHANNELS; c++) begin
      if (CH_W'(c) == ch_sel) pred_sel = pred_r[c];
      if (CH_W'(c) == ch_r) begin
        pred_cur = pred_r[c];
        step_cur = step_r[c];
      end
    end
  end

  assign diff    = MAG_W'(in_sample) - MAG_W'(pred_sel);
  assign mag     = diff[MAG_W-1] ? MAG_W'(-diff) : MAG_W'(diff);
  assign quarter = step_cur >> 2;
  assign more    = (rem_r >= MAG_W'(quarter)) && (code_r != CODE_MAX);

  // rebuild the prediction the way a decoder would
  always_comb begin
    delta = DELTA_W'(step_cur >> 3);
    if (code_r[0]) delta = delta + DELTA_W'(step_cur >> 2);
    if (code_r[1]) delta = delta + DELTA_W'(step_cur >> 1);
    if (code_r[2]) delta = delta + DELTA_W'(step_cur);
    pred_wide = neg_r ? (WIDE_W'(pred_cur) - WIDE_W'(delta))
                      : (WIDE_W'(pred_cur) + WIDE_W'(delta));
    if (pred_wide > WIDE_W'(PRED_MAX))      pred_clamp = PRED_MAX;
    else if (pred_wide < WIDE_W'(PRED_MIN)) pred_clamp = PRED_MIN;
    else                                    pred_clamp = pred_wide[SAMPLE_W-1:0];
  end

  assign ns_raw = prod_r[PROD_W-1:SCALE_SHIFT];
  always_comb begin
    if (ns_raw < (PROD_W-SCALE_SHIFT)'(STEP_MIN))      ns_clamp = STEP_MIN;
    else if (ns_raw > (PROD_W-SCALE_SHIFT)'(STEP_MAX)) ns_clamp = STEP_MAX;
    else                                               ns_clamp = ns_raw[STEP_W-1:0];
  end

  assign nib    = {neg_r, code_r};
  assign emit   = pending_r || eos_r;
  assign in_ready = (uw.op == OP_WAIT);
  assign accept = in_valid && in_ready;

  always_comb begin
    case (uw.cond)
      JC_NEVER:     jump = 1'b0;
      JC_NO_ACCEPT: jump = !accept;
      JC_MORE:      jump = more;
      JC_OUT_BUSY:  jump = emit && out_valid_r && !out_ready;
      default:      jump = 1'b0;
    endcase
    pc_nxt = jump ? uw.target : PC_W'(pc_r + 1'b1);
  end

  assign commit = (uw.op == OP_COMMIT) && !jump;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= PC_WAIT;
      num_ch_r    <= CFG_W'(1);
      ch_idx_r    <= '0;
      pending_r   <= 1'b0;
      held_r      <= '0;
      out_valid_r <= 1'b0;
      for (int c = 0; c < MAX_CHANNELS; c++) begin
        pred_r[c] <= '0;
        step_r[c] <= STEP_MIN;
      end
    end else begin
      pc_r <= pc_nxt;
      if (cfg_wr_en) num_ch_r <= cfg_wr_data;

      // a new byte may land in the same cycle the old one is taken
      if (commit && emit) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end

      if (commit) begin
        if (emit) begin
          out_final_r <= eos_r;
          out_byte_r  <= pending_r ? {nib, held_r} : {{(BYTE_W-NIB_W){1'b0}}, nib};
        end
        if (eos_r) begin
          ch_idx_r  <= '0;
          pending_r <= 1'b0;
          held_r    <= '0;
          for (int c = 0; c < MAX_CHANNELS; c++) begin
            pred_r[c] <= '0;
            step_r[c] <= STEP_MIN;
          end
        end else begin
          ch_idx_r  <= ch_next;
          pending_r <= !pending_r;
          held_r    <= pending_r ? '0 : nib;
          for (int c = 0; c < MAX_CHANNELS; c++) begin
            if (CH_W'(c) == ch_r) begin
              pred_r[c] <= pred_upd_r;
              step_r[c] <= ns_clamp;
            end
          end
        end
      end
    end
  end

  // datapath registers, no reset
  always_ff @(posedge clk) begin
    unique case (uw.op)
      OP_WAIT: begin
        if (accept) begin
          ch_r   <= ch_sel;
          eos_r  <= in_end_of_stream;
          neg_r  <= diff[MAG_W-1];
          rem_r  <= mag;
          code_r <= '0;
        end
      end
      OP_QUANT: begin
        if (more) begin
          rem_r  <= rem_r - MAG_W'(quarter);
          code_r <= code_r + 1'b1;
        end
      end
      OP_MUL: begin
        prod_r     <= PROD_W'(step_scale(code_r)) * PROD_W'(step_cur);
        pred_upd_r <= pred_clamp;
      end
      OP_COMMIT: begin
      end
      default: begin
      end
    endcase
  end

  assign out_valid       = out_valid_r;
  assign out_packed_byte = out_byte_r;
  assign out_final_byte  = out_final_r;

  a_step_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (step_r[0] >= STEP_MIN) && (step_r[0] <= STEP_MAX))
    else $error("step size of channel 0 left its clamp range");

  a_quant_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (uw.op == OP_QUANT) && (code_r == CODE_MAX) |=> (pc_r == PC_MUL))
    else $error("quantizer loop ran past the top code");

  a_eos_clears: assert property (@(posedge clk) disable iff (!rst_n)
    commit && eos_r |=> !pending_r && (ch_idx_r == '0))
    else $error("end of stream did not clear packing state");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    commit && emit |-> !out_valid_r || out_ready)
    else $error("result written over a byte not yet taken");

endmodule
